@@ rtl/eve_pkg.sv @@
// Encoder value entry: codes and constants for the core.
// Holds request codes, register indexes and step limits; no dependencies.
package eve_pkg;

  // Request codes carried by req_type
  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_EDGE  = 2'd1;
  localparam logic [1:0] REQ_PRESS = 2'd2;

  // Configuration register indexes (byte address is 4 * index)
  localparam int unsigned ADDR_W = 5;
  localparam logic [2:0] REG_MIN_VALUE      = 3'd0;
  localparam logic [2:0] REG_MAX_VALUE      = 3'd1;
  localparam logic [2:0] REG_THRESHOLD      = 3'd2;
  localparam logic [2:0] REG_STEP_SIZE      = 3'd3;
  localparam logic [2:0] REG_GRADUAL_ENABLE = 3'd4;
  localparam logic [2:0] REG_MAX_STEP       = 3'd5;

  // Step register width and bounds
  localparam int unsigned STEP_W = 7;
  localparam logic [STEP_W-1:0] STEP_MIN = 7'd1;
  localparam logic [STEP_W-1:0] STEP_MAX = 7'd127;

  // Edge counter width
  localparam int unsigned EDGE_W = 9;

endpackage

@@ rtl/encoder_value_entry_core.sv @@
// Encoder value entry top level: handshake, configuration port and step sequencer.
// Depends on eve_pkg and the iterative divider eve_div.
//
//  channel | direction | handshake           | beat contents
//  in      | sink      | in_valid/in_ready   | req_type, start_value, b_level
//  out     | source    | out_valid/out_ready | value_out, changed, done_res
//  cfg     | sink      | APB psel/penable    | six registers at 4*index
//
// A beat whose result needs no new step (edge without change, press, fixed-step
// start) leaves the sequencer idle. A beat that recomputes the step in gradual
// mode drops input ready after acceptance while the sequencer passes MUL, LOAD,
// DIV and FIN, with the one-bit-a-cycle divider working over the VALUE_BITS+9
// bit product; with min equal to max the divider is skipped and only MUL, LOAD
// and FIN are passed. The result is registered at acceptance and may wait
// on out_ready while the step is worked out. Reset loads the register defaults,
// value 0, step 1, edge count 0.
module encoder_value_entry_core #(
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   req_type_i,
  input  logic signed [VALUE_BITS-1:0] start_value_i,
  input  logic                         b_level_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [VALUE_BITS-1:0] value_out_o,
  output logic                         changed_o,
  output logic                         done_res_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [eve_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  import eve_pkg::*;

  localparam int unsigned VW = VALUE_BITS + 1;
  localparam int unsigned PW = VALUE_BITS + 9;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_LOAD = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  // Configuration registers
  logic signed [VALUE_BITS-1:0] min_q, max_q;
  logic [STEP_W-1:0]            thr_q, step_size_q, max_step_q;
  logic                         grad_q;

  // Entry state
  logic signed [VALUE_BITS-1:0] cur_q, cur_d;
  logic [STEP_W-1:0]            step_q, step_d;
  logic signed [EDGE_W-1:0]     ec_q, ec_d;
  logic [2:0]                   state_q, state_d;

  // Step map datapath
  logic signed [PW-1:0]         prod_q;
  logic signed [VW-1:0]         span_q;
  logic                         neg_q;
  logic                         span_zero_q;

  // Output register
  logic                         out_valid_q;
  logic signed [VALUE_BITS-1:0] value_out_q;
  logic                         changed_q, done_q;

  logic                         in_fire;
  logic                         cfg_wr;
  logic [2:0]                   cfg_idx;

  logic signed [VW-1:0]         cur_ext, min_ext, max_ext, st_ext;
  logic signed [VW-1:0]         up_val, dn_val;
  logic signed [EDGE_W-1:0]     ec_step, thr_ext;
  logic signed [VALUE_BITS-1:0] new_val;
  logic                         new_changed, new_done;
  logic                         recompute;

  logic signed [VW-1:0]         diff;
  logic signed [7:0]            one_minus_ms;
  logic signed [PW-1:0]         prod_d;
  logic signed [VW-1:0]         span_d;

  logic                         div_start, div_done;
  logic [PW-1:0]                div_num, div_quot;
  logic [VW-1:0]                div_den;
  logic signed [PW-1:0]         q_signed, step_sum;
  logic [STEP_W-1:0]            fixed_step, map_step;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q       <= '0;
      max_q       <= VALUE_BITS'(100);
      thr_q       <= 7'd1;
      step_size_q <= 7'd1;
      grad_q      <= 1'b0;
      max_step_q  <= 7'd10;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_MIN_VALUE:      min_q       <= pwdata[VALUE_BITS-1:0];
        REG_MAX_VALUE:      max_q       <= pwdata[VALUE_BITS-1:0];
        REG_THRESHOLD:      thr_q       <= pwdata[STEP_W-1:0];
        REG_STEP_SIZE:      step_size_q <= pwdata[STEP_W-1:0];
        REG_GRADUAL_ENABLE: grad_q      <= pwdata[0];
        REG_MAX_STEP:       max_step_q  <= pwdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    case (cfg_idx)
      REG_MIN_VALUE:      prdata = 32'(min_q);
      REG_MAX_VALUE:      prdata = 32'(max_q);
      REG_THRESHOLD:      prdata = {25'd0, thr_q};
      REG_STEP_SIZE:      prdata = {25'd0, step_size_q};
      REG_GRADUAL_ENABLE: prdata = {31'd0, grad_q};
      REG_MAX_STEP:       prdata = {25'd0, max_step_q};
      default:            prdata = '0;
    endcase
  end

  // Handshake
  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;

  // Edge processing: count, compare with threshold, bounded move
  assign cur_ext = {cur_q[VALUE_BITS-1], cur_q};
  assign min_ext = {min_q[VALUE_BITS-1], min_q};
  assign max_ext = {max_q[VALUE_BITS-1], max_q};
  assign st_ext  = $signed({{(VW-STEP_W){1'b0}}, step_q});
  assign up_val  = cur_ext + st_ext;
  assign dn_val  = cur_ext - st_ext;
  assign ec_step = b_level_i ? (ec_q + EDGE_W'(1)) : (ec_q - EDGE_W'(1));
  assign thr_ext = $signed({{(EDGE_W-STEP_W){1'b0}}, thr_q});
  assign fixed_step = (step_size_q == '0) ? STEP_MIN : step_size_q;

  always_comb begin
    new_val     = cur_q;
    new_changed = 1'b0;
    new_done    = 1'b0;
    recompute   = 1'b0;
    ec_d        = ec_q;
    case (req_type_i)
      REQ_START: begin
        new_val   = start_value_i;
        recompute = grad_q;
      end
      REQ_EDGE: begin
        ec_d = ec_step;
        if (ec_step > thr_ext) begin
          if (up_val <= max_ext) begin
            new_val = up_val[VALUE_BITS-1:0];
          end
          ec_d = '0;
        end else if (ec_step < -thr_ext) begin
          if (dn_val >= min_ext) begin
            new_val = dn_val[VALUE_BITS-1:0];
          end
          ec_d = '0;
        end
        new_changed = (new_val != cur_q);
        recompute   = new_changed && grad_q;
      end
      REQ_PRESS: begin
        new_done = 1'b1;
      end
      default: ;
    endcase
  end

  // Step map: product, then signed division through the divider instance
  assign diff         = cur_ext - min_ext;
  assign one_minus_ms = 8'sd1 - $signed({1'b0, max_step_q});
  assign prod_d       = diff * one_minus_ms;
  assign span_d       = max_ext - min_ext;

  assign div_start = (state_q == ST_LOAD) && !span_zero_q;
  assign div_num   = prod_q[PW-1] ? PW'(-prod_q) : PW'(prod_q);
  assign div_den   = span_q[VW-1] ? VW'(-span_q) : VW'(span_q);

  eve_div #(
    .NUM_W (PW),
    .DEN_W (VW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Apply quotient sign, add max_step and clamp to the step range
  assign q_signed = span_zero_q ? '0 : (neg_q ? -$signed(div_quot) : $signed(div_quot));
  assign step_sum = q_signed + $signed({{(PW-STEP_W){1'b0}}, max_step_q});
  always_comb begin
    if (step_sum < $signed(PW'(1))) begin
      map_step = STEP_MIN;
    end else if (step_sum > $signed(PW'(127))) begin
      map_step = STEP_MAX;
    end else begin
      map_step = step_sum[STEP_W-1:0];
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    cur_d   = cur_q;
    step_d  = step_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          cur_d = new_val;
          if (recompute) begin
            state_d = ST_MUL;
          end else if (req_type_i == REQ_START) begin
            step_d = fixed_step;
          end
        end
      end
      ST_MUL:  state_d = ST_LOAD;
      ST_LOAD: state_d = span_zero_q ? ST_FIN : ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        step_d  = map_step;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control and entry state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cur_q       <= '0;
      step_q      <= STEP_MIN;
      ec_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      step_q  <= step_d;
      if (in_fire) begin
        ec_q <= ec_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold result beat and step map operands
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      value_out_q <= new_val;
      changed_q   <= new_changed;
      done_q      <= new_done;
    end
    if (state_q == ST_MUL) begin
      prod_q      <= prod_d;
      span_q      <= span_d;
      neg_q       <= prod_d[PW-1] ^ span_d[VW-1];
      span_zero_q <= (span_d == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_out_o = value_out_q;
  assign changed_o   = changed_q;
  assign done_res_o  = done_q;

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (state_q == ST_IDLE))
    else $error("input ready outside idle");

  a_step_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q != '0)
    else $error("step register is zero");

  a_edge_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ec_q <= $signed(EDGE_W'(127))) && (ec_q >= -$signed(EDGE_W'(127))))
    else $error("edge count out of range");

  a_div_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside divide state");
`endif

endmodule

@@ rtl/eve_div.sv @@
// Encoder value entry: iterative unsigned restoring divider, one bit a cycle.
// Stand-alone; used by encoder_value_entry_core for the gradual step map.
module eve_div #(
  parameter int unsigned NUM_W = 25,
  parameter int unsigned DEN_W = 17
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;

  // Shift in the next dividend bit and trial-subtract the divisor
  assign rem_sh  = {rem_q, num_q[NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(NUM_W);
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
    end else if (busy_q) begin
      // Keep the difference when it did not go negative
      if (!rem_sub[DEN_W]) begin
        rem_d = rem_sub[DEN_W-1:0];
        num_d = {num_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[DEN_W-1:0];
        num_d = {num_q[NUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  // Last step lands at this edge; quotient is in num_q afterwards
  assign done_o = busy_q && (cnt_q == CNT_W'(1));
  assign quot_o = num_q;

endmodule
